[sv/spimdc_pkg.sv]
// Shared types, register codes and helpers of the SPI controller with data/command line.
package spimdc_pkg;

    // Widths of the word fields
    localparam int unsigned WORD_W    = 16;
    localparam int unsigned NBITS_W   = 5;
    localparam int unsigned POS_W     = 4;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WORD_BITS      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_PHASE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_POLARITY = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESCALE       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_DIVIDER   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE         = 3'd5;

    // Reset values of the registers
    localparam logic [NBITS_W-1:0]   RST_WORD_BITS = 5'd8;
    localparam logic [CFG_DAT_W-1:0] RST_PRESCALE  = 8'd4;
    localparam logic [CFG_DAT_W-1:0] RST_RATE_DIV  = 8'd1;

    // Word size limits
    localparam logic [NBITS_W-1:0] MIN_BITS = 5'd4;
    localparam logic [NBITS_W-1:0] MAX_BITS = 5'd16;

    typedef struct packed {
        logic              mode;
        logic [WORD_W-1:0] tx_word;
        logic [WORD_W-1:0] partner_word;
    } t_in_word;

    typedef struct packed {
        logic              mosi_bit;
        logic              dc_level;
        logic [POS_W-1:0]  bit_position;
        logic              last_bit;
        logic [WORD_W-1:0] rx_word;
    } t_out_word;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_DAT_W-1:0] data;
    } t_cfg_word;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic emit;
    } t_ctl;

    // Status from the datapath to the controller
    typedef struct packed {
        logic tick_done;
        logic last;
    } t_sts;

    // Saturate the configured word size to four..sixteen
    function automatic logic [NBITS_W-1:0] eff_bits(input logic [NBITS_W-1:0] bits);
        logic [NBITS_W-1:0] res;
        res = bits;
        if (bits < MIN_BITS) begin
            res = MIN_BITS;
        end else if (bits > MAX_BITS) begin
            res = MAX_BITS;
        end
        return res;
    endfunction

endpackage

[sv/spimdc_if.sv]
// Handshake channel interfaces: input word, result word and configuration write.
interface spimdc_in_if;
    logic                valid;
    logic                ready;
    spimdc_pkg::t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface spimdc_out_if;
    logic                 valid;
    logic                 ready;
    spimdc_pkg::t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface spimdc_cfg_if;
    logic                 valid;
    logic                 ready;
    spimdc_pkg::t_cfg_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[sv/spimdc_datapath.sv]
// Datapath: shift registers, bit counter, bit-period timer and result register.
module spimdc_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  spimdc_pkg::t_ctl                    i_ctl,
    input  spimdc_pkg::t_in_word                i_item,
    input  logic [spimdc_pkg::NBITS_W-1:0]      i_word_bits,
    input  logic [spimdc_pkg::CFG_DAT_W-1:0]    i_prescale,
    input  logic [spimdc_pkg::CFG_DAT_W-1:0]    i_rate_div,
    output spimdc_pkg::t_sts                    o_sts,
    output spimdc_pkg::t_out_word               o_result
);

    logic [spimdc_pkg::WORD_W-1:0]    r_shift_out, r_shift_in, r_partner;
    logic [spimdc_pkg::NBITS_W-1:0]   r_nbits, r_bit_cnt;
    logic                             r_dc_line;
    logic [spimdc_pkg::CFG_DAT_W-1:0] r_pre_cnt, r_div_cnt;
    spimdc_pkg::t_out_word            r_result;

    logic [spimdc_pkg::NBITS_W-1:0]   n_nbits;
    logic [spimdc_pkg::NBITS_W-1:0]   n_align;
    logic [spimdc_pkg::CFG_DAT_W-1:0] pre_term;
    logic [spimdc_pkg::WORD_W-1:0]    n_shift_in;
    logic                             last;
    logic                             pre_done;

    // Left-align the word so the MSB of the sized word sits at the top
    assign n_nbits = spimdc_pkg::eff_bits(i_word_bits);
    assign n_align = spimdc_pkg::MAX_BITS - n_nbits;

    // Bit-period timer terminal counts; a zero prescale acts as one
    assign pre_term = (i_prescale == '0) ? '0 : i_prescale - 8'd1;
    assign pre_done = (r_pre_cnt == pre_term);

    assign last       = (r_bit_cnt == r_nbits - 5'd1);
    assign n_shift_in = {r_shift_in[spimdc_pkg::WORD_W-2:0], r_partner[spimdc_pkg::WORD_W-1]};

    assign o_sts.tick_done = pre_done && (r_div_cnt == i_rate_div);
    assign o_sts.last      = last;
    assign o_result        = r_result;

    // Advance the bit-period timer; restart it on load and on every emitted bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.load || i_ctl.emit) begin
            r_pre_cnt <= '0;
            r_div_cnt <= '0;
        end else if (!o_sts.tick_done) begin
            if (pre_done) begin
                r_pre_cnt <= '0;
                r_div_cnt <= r_div_cnt + 8'd1;
            end else begin
                r_pre_cnt <= r_pre_cnt + 8'd1;
            end
        end
    end

    // Load the word, then shift one bit per emitted result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_cnt <= '0;
            r_nbits   <= spimdc_pkg::RST_WORD_BITS;
            r_dc_line <= 1'b1;
        end else if (i_ctl.load) begin
            r_bit_cnt <= '0;
            r_nbits   <= n_nbits;
            r_dc_line <= ~i_item.mode;
        end else if (i_ctl.emit) begin
            r_bit_cnt <= r_bit_cnt + 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_shift_out <= i_item.tx_word << n_align;
            r_partner   <= i_item.partner_word << n_align;
            r_shift_in  <= '0;
        end else if (i_ctl.emit) begin
            r_shift_out <= r_shift_out << 1;
            r_partner   <= r_partner << 1;
            r_shift_in  <= n_shift_in;
        end
    end

    // Capture the result word for the output channel
    always_ff @(posedge i_clk) begin
        if (i_ctl.emit) begin
            r_result.mosi_bit     <= r_shift_out[spimdc_pkg::WORD_W-1];
            r_result.dc_level     <= r_dc_line;
            r_result.bit_position <= r_bit_cnt[spimdc_pkg::POS_W-1:0];
            r_result.last_bit     <= last;
            r_result.rx_word      <= last ? n_shift_in : '0;
        end
    end

endmodule

[sv/spimdc_ctrl.sv]
// Controller: word sequencing state machine and result valid flag.
module spimdc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_enable,
    input  logic             i_out_ready,
    input  spimdc_pkg::t_sts i_sts,
    output spimdc_pkg::t_ctl o_ctl,
    output logic             o_in_ready,
    output logic             o_out_valid
);

    typedef enum logic {
        S_IDLE,
        S_SHIFT
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;
    logic   accept;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    // Load on an enabled word; drop it when disabled; emit when timer and output allow
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_ctl.load  = 1'b0;
        o_ctl.emit  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept && i_enable) begin
                    o_ctl.load = 1'b1;
                    n_state    = S_SHIFT;
                end
            end
            S_SHIFT: begin
                if (i_sts.tick_done && out_free) begin
                    o_ctl.emit  = 1'b1;
                    n_out_valid = 1'b1;
                    if (i_sts.last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and the result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_emit_in_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.emit |-> r_state == S_SHIFT)
        else $error("bit emitted outside a word");

    a_last_ends_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ctl.emit && i_sts.last) |=> (r_state == S_IDLE && r_out_valid))
        else $error("word did not end after its last bit");

    a_load_starts_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.load |=> r_state == S_SHIFT)
        else $error("load did not start a word");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !o_ctl.emit)
        else $error("result overwritten while stalled");

endmodule

[sv/spi_master_with_data_command_line_core.sv]
// Top level of the SPI controller with data/command line: registers, controller, datapath.
//
//  port    dir  payload                                         handshake
//  i_in    in   mode, tx_word, partner_word                     valid/ready
//  o_out   out  mosi_bit, dc_level, bit_position, last_bit, rx  valid/ready
//  i_cfg   in   index, data                                     valid/ready (always ready)
//
// One word is loaded, then sent as word_bits bits, each bit period set by prescale
// and rate_divider as counted by the bit-period timer.
// At reset: word_bits 8, prescale 4, rate_divider 1, disabled, data/command line high.
// A stalled result holds the next bit until the output word is taken.
// Words arriving while disabled are taken and dropped.
module spi_master_with_data_command_line_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    spimdc_in_if.sink    i_in,
    spimdc_out_if.source o_out,
    spimdc_cfg_if.sink   i_cfg
);

    logic [spimdc_pkg::NBITS_W-1:0]   r_word_bits;
    logic [spimdc_pkg::CFG_DAT_W-1:0] r_prescale;
    logic [spimdc_pkg::CFG_DAT_W-1:0] r_rate_div;
    logic                             r_enable;

    spimdc_pkg::t_ctl ctl;
    spimdc_pkg::t_sts sts;

    assign i_cfg.ready = 1'b1;

    // Write the configuration registers; phase and polarity writes have no effect here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_bits <= spimdc_pkg::RST_WORD_BITS;
            r_prescale  <= spimdc_pkg::RST_PRESCALE;
            r_rate_div  <= spimdc_pkg::RST_RATE_DIV;
            r_enable    <= 1'b0;
        end else if (i_cfg.valid) begin
            case (i_cfg.data.index)
                spimdc_pkg::CFG_WORD_BITS:
                    r_word_bits <= i_cfg.data.data[spimdc_pkg::NBITS_W-1:0];
                spimdc_pkg::CFG_PRESCALE:     r_prescale <= i_cfg.data.data;
                spimdc_pkg::CFG_RATE_DIVIDER: r_rate_div <= i_cfg.data.data;
                spimdc_pkg::CFG_ENABLE:       r_enable   <= i_cfg.data.data[0];
                default: begin
                end
            endcase
        end
    end

    spimdc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_enable    (r_enable),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_ctl       (ctl),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid)
    );

    spimdc_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_item      (i_in.data),
        .i_word_bits (r_word_bits),
        .i_prescale  (r_prescale),
        .i_rate_div  (r_rate_div),
        .o_sts       (sts),
        .o_result    (o_out.data)
    );

endmodule
